@@ rtl/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Word layouts, field codes, register indexes and the control word format
// shared by the sender window datapath and its microcode sequencer.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int KIND_W      = 2;
    localparam int ACK_W       = 8;
    localparam int ACTION_W    = 2;
    localparam int SEQ_FIELD_W = 8;
    localparam int WS_W        = 6;
    localparam int TO_W        = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int STEP_W      = 3;

    localparam logic [KIND_W-1:0] KIND_NEW  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_SEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RETX = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic [WS_W-1:0] WS_RESET = 6'd4;
    localparam logic [TO_W-1:0] TO_RESET = 16'd2000;

    localparam logic [STEP_W-1:0] STEP_FETCH = 3'd0;
    localparam logic [STEP_W-1:0] STEP_NEW   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ACK   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_TICK  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_RETX  = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ACK_W-1:0]  ack_number;
    } in_word_t;

    typedef struct packed {
        logic [ACTION_W-1:0]    action;
        logic [SEQ_FIELD_W-1:0] sequence_res;
        logic                   last;
    } out_word_t;

    typedef enum logic [1:0] {
        EMIT_NONE = 2'd0,
        EMIT_NEW  = 2'd1,
        EMIT_RETX = 2'd2
    } emit_t;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_DISPATCH = 2'd1,
        COND_FIRE     = 2'd2,
        COND_LAST     = 2'd3
    } cond_t;

    typedef struct packed {
        logic              accept;
        emit_t             emit;
        logic              do_ack;
        logic              do_tick;
        cond_t             cond;
        logic [STEP_W-1:0] jump_target;
        logic [STEP_W-1:0] next_target;
    } ucode_t;

    typedef struct packed {
        logic              in_valid;
        logic [KIND_W-1:0] kind;
        logic              slot_free;
        logic              fire;
        logic              last;
    } flags_t;

endpackage

@@ rtl/go_back_n_sender_window.sv @@
// Order: a request is taken in the fetch step and its send or refusal word
// is registered in the execute step; retransmission words follow the tick step.
// Steps: every word takes a fetch, then one execute step, an unused kind the
// fetch only; a timeout adds one retransmission step per outstanding frame,
// one per cycle unless stalled. A stalled result word holds the sequencer.
// Reset: synchronous, active low; window and timer state return to zero,
// the window size to 4 and the timeout to 2000 ticks.
// ----------------------------------------------------------------------------
// Go-Back-N sender window
// Numbers and sends new frames within the window, slides the window base on
// cumulative acknowledgements and resends the whole window on timeout.
// ----------------------------------------------------------------------------
module go_back_n_sender_window #(
    parameter int SEQ_BITS   = 8,
    parameter int WINDOW_MAX = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  gbn_pkg::in_word_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output gbn_pkg::out_word_t           m_data,
    input  logic                         cfg_wr_en,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gbn_pkg::*;

    localparam int CMP_W  = (SEQ_BITS > 7) ? SEQ_BITS : 7;
    localparam int WMAX_I = (WINDOW_MAX < (1 << SEQ_BITS) - 1) ?
                            WINDOW_MAX : (1 << SEQ_BITS) - 1;
    localparam logic [CMP_W-1:0] WMAX_C = CMP_W'(WMAX_I);

    logic [WS_W-1:0]     ws_reg;
    logic [TO_W-1:0]     to_reg;
    logic [SEQ_BITS-1:0] base_reg;
    logic [SEQ_BITS-1:0] next_reg;
    logic [TO_W-1:0]     count_reg;
    logic                running_reg;
    logic [SEQ_BITS-1:0] idx_reg;
    logic [ACK_W-1:0]    ack_reg;
    logic                m_valid_reg;
    out_word_t           m_data_reg;
    out_word_t           m_data_next;

    ucode_t              uword;
    flags_t              flags;
    logic                exec;

    logic [SEQ_BITS-1:0] outs;
    logic [SEQ_BITS-1:0] outs_m1;
    logic [CMP_W-1:0]    eff_win;
    logic                room;
    logic [SEQ_BITS-1:0] ack_s;
    logic [SEQ_BITS-1:0] ack_off;
    logic [SEQ_BITS-1:0] new_base;
    logic                ack_ok;
    logic [TO_W-1:0]     count_inc;
    logic [TO_W-1:0]     limit;
    logic                expire;
    logic [SEQ_BITS-1:0] retx_seq;
    logic                retx_last;
    logic                slot_free;

    assign outs    = next_reg - base_reg;
    assign outs_m1 = outs - 1'b1;

    always_comb begin
        eff_win = CMP_W'(ws_reg);
        if (ws_reg == '0) begin
            eff_win = CMP_W'(1);
        end
        if (eff_win > WMAX_C) begin
            eff_win = WMAX_C;
        end
    end

    assign room      = CMP_W'(outs) < eff_win;
    assign ack_s     = SEQ_BITS'(ack_reg);
    assign ack_off   = ack_s - base_reg;
    assign ack_ok    = ack_off < outs;
    assign new_base  = ack_s + 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign limit     = (to_reg == '0) ? TO_W'(1) : to_reg;
    assign expire    = running_reg && !(count_inc < limit);
    assign retx_seq  = base_reg + idx_reg;
    assign retx_last = idx_reg == outs_m1;
    assign slot_free = !m_valid_reg || m_ready;

    assign flags.in_valid  = s_valid;
    assign flags.kind      = s_data.kind;
    assign flags.slot_free = slot_free;
    assign flags.fire      = expire && (outs != '0);
    assign flags.last      = retx_last;

    gbn_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uword   (uword),
        .exec    (exec)
    );

    always_comb begin
        case (uword.emit)
            EMIT_NEW: begin
                if (room) begin
                    m_data_next.action       = ACT_SEND;
                    m_data_next.sequence_res = SEQ_FIELD_W'(next_reg);
                end else begin
                    m_data_next.action       = ACT_FULL;
                    m_data_next.sequence_res = '0;
                end
                m_data_next.last = 1'b1;
            end
            EMIT_RETX: begin
                m_data_next.action       = ACT_RETX;
                m_data_next.sequence_res = SEQ_FIELD_W'(retx_seq);
                m_data_next.last         = retx_last;
            end
            default: begin
                m_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg      <= WS_RESET;
            to_reg      <= TO_RESET;
            base_reg    <= '0;
            next_reg    <= '0;
            count_reg   <= '0;
            running_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WINDOW_SIZE:   ws_reg <= cfg_wdata[WS_W-1:0];
                    CFG_TIMEOUT_TICKS: to_reg <= cfg_wdata[TO_W-1:0];
                    default:           ws_reg <= ws_reg;
                endcase
            end
            if (exec && (uword.emit == EMIT_NEW) && room) begin
                next_reg <= next_reg + 1'b1;
                if (!running_reg) begin
                    running_reg <= 1'b1;
                    count_reg   <= '0;
                end
            end
            if (exec && uword.do_ack && ack_ok) begin
                base_reg    <= new_base;
                count_reg   <= '0;
                running_reg <= new_base != next_reg;
            end
            if (exec && uword.do_tick && running_reg) begin
                if (expire) begin
                    count_reg <= '0;
                end else begin
                    count_reg <= count_inc;
                end
            end
            if (exec && (uword.emit != EMIT_NONE)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec && uword.accept) begin
            ack_reg <= s_data.ack_number;
        end
        if (exec && uword.do_tick && expire) begin
            idx_reg <= '0;
        end else if (exec && (uword.emit == EMIT_RETX)) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (exec && (uword.emit != EMIT_NONE)) begin
            m_data_reg <= m_data_next;
        end
    end

    assign s_ready = uword.accept;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/gbn_useq.sv @@
// ----------------------------------------------------------------------------
// Go-Back-N microcode sequencer
// Holds the step counter and the control store, and picks the next step
// from the jump condition of the current control word.
// ----------------------------------------------------------------------------
module gbn_useq (
    input  logic            aclk,
    input  logic            aresetn,
    input  gbn_pkg::flags_t flags,
    output gbn_pkg::ucode_t uword,
    output logic            exec
);
    import gbn_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] dispatch;
    logic              stall;
    logic              taken;

    function automatic ucode_t rom(input logic [STEP_W-1:0] s);
        ucode_t w;
        w             = '0;
        w.emit        = EMIT_NONE;
        w.cond        = COND_ALWAYS;
        w.jump_target = STEP_FETCH;
        w.next_target = STEP_FETCH;
        case (s)
            STEP_FETCH: begin
                w.accept = 1'b1;
                w.cond   = COND_DISPATCH;
            end
            STEP_NEW: begin
                w.emit = EMIT_NEW;
            end
            STEP_ACK: begin
                w.do_ack = 1'b1;
            end
            STEP_TICK: begin
                w.do_tick     = 1'b1;
                w.cond        = COND_FIRE;
                w.jump_target = STEP_RETX;
            end
            STEP_RETX: begin
                w.emit        = EMIT_RETX;
                w.cond        = COND_LAST;
                w.next_target = STEP_RETX;
            end
            default: begin
                w.cond = COND_ALWAYS;
            end
        endcase
        return w;
    endfunction

    assign uword = rom(step_reg);

    always_comb begin
        case (flags.kind)
            KIND_NEW:  dispatch = STEP_NEW;
            KIND_ACK:  dispatch = STEP_ACK;
            KIND_TICK: dispatch = STEP_TICK;
            default:   dispatch = STEP_FETCH;
        endcase
    end

    assign stall = (uword.accept && !flags.in_valid) ||
                   ((uword.emit != EMIT_NONE) && !flags.slot_free);
    assign exec  = !stall;

    always_comb begin
        case (uword.cond)
            COND_FIRE: taken = flags.fire;
            COND_LAST: taken = flags.last;
            default:   taken = 1'b1;
        endcase
    end

    always_comb begin
        if (stall) begin
            step_next = step_reg;
        end else if (uword.cond == COND_DISPATCH) begin
            step_next = dispatch;
        end else if (taken) begin
            step_next = uword.jump_target;
        end else begin
            step_next = uword.next_target;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/gbn_checker.sv @@
// ----------------------------------------------------------------------------
// Go-Back-N sender port checker
// Watches the word channels of the sender window and flags results that
// break the output rules of the block.
// ----------------------------------------------------------------------------
module gbn_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input gbn_pkg::out_word_t m_data
);
    import gbn_pkg::*;

    // No result word may be left pending across reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    // Sends and refusals are always the only result of their request.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action != ACT_RETX) |-> m_data.last)
        else $error("send or refusal word without last");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action == ACT_FULL) |-> (m_data.sequence_res == '0))
        else $error("refusal word carries a sequence number");

    // No new word is taken while a retransmission burst is still running.
    a_burst_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.action == ACT_RETX) && !m_data.last |-> !s_ready)
        else $error("input word taken during retransmission burst");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (.*);

@@ tb/sv/go_back_n_sender_window_tb.sv @@
// ----------------------------------------------------------------------------
// Go-Back-N sender window testbench
// Drives new frame requests, acknowledgements and timer ticks into the sender
// window and checks every action word against a cycle-free window model kept
// alongside. Covers the default settings, window and timeout extremes,
// shrinking the window, full-window retransmission bursts, a long output
// stall, and random traffic under several settings with bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_tb;
    import gbn_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int WATCHDOG_CYCLES = 300000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_PRINTED     = 25;

    localparam int READY_ALWAYS  = 0;
    localparam int READY_RANDOM  = 1;
    localparam int READY_PATTERN = 2;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_word_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_word_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    go_back_n_sender_window u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Window model state and its copy of the registers.
    logic [WS_W-1:0]        win_size_reg = WS_RESET;
    logic [TO_W-1:0]        timeout_reg  = TO_RESET;
    logic [SEQ_FIELD_W-1:0] win_base     = '0;
    logic [SEQ_FIELD_W-1:0] next_seq     = '0;
    logic [TO_W-1:0]        tick_count   = '0;
    logic                   timer_on     = 1'b0;

    out_word_t sender_actions_q[$];

    int err_count    = 0;
    int words_in     = 0;
    int sends_seen   = 0;
    int retx_seen    = 0;
    int refused_seen = 0;
    int longest_burst = 0;
    int reg_writes   = 0;
    int cycle_count  = 0;

    int ready_mode   = READY_ALWAYS;
    int hold_request = 0;
    int hold_left    = 0;
    logic [7:0] ready_pattern = 8'b1011_0110;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        err_count++;
    endtask

    function automatic int effective_window();
        int w;
        w = int'(win_size_reg);
        if (w < 1) w = 1;
        if (w > 32) w = 32;
        if (w > 255) w = 255;
        return w;
    endfunction

    task automatic push_action(input logic [ACTION_W-1:0] act,
                               input logic [SEQ_FIELD_W-1:0] seq, input logic lst);
        out_word_t r;
        r.action       = act;
        r.sequence_res = seq;
        r.last         = lst;
        sender_actions_q.push_back(r);
    endtask

    task automatic advance_window(input in_word_t w);
        logic [SEQ_FIELD_W-1:0] outs;
        logic [SEQ_FIELD_W-1:0] ack_off;
        int limit;
        int i;
        outs    = next_seq - win_base;
        ack_off = w.ack_number - win_base;
        case (w.kind)
            KIND_NEW: begin
                if (int'(outs) < effective_window()) begin
                    push_action(ACT_SEND, next_seq, 1'b1);
                    next_seq = next_seq + 1'b1;
                    if (!timer_on) begin
                        timer_on   = 1'b1;
                        tick_count = '0;
                    end
                end else begin
                    push_action(ACT_FULL, '0, 1'b1);
                end
            end
            KIND_ACK: begin
                if (ack_off < outs) begin
                    win_base   = w.ack_number + 1'b1;
                    tick_count = '0;
                    timer_on   = (win_base != next_seq);
                end
            end
            KIND_TICK: begin
                if (timer_on) begin
                    limit = (timeout_reg == 0) ? 1 : int'(timeout_reg);
                    tick_count = tick_count + 1'b1;
                    if (int'(tick_count) >= limit) begin
                        tick_count = '0;
                        for (i = 0; i < int'(outs); i++) begin
                            push_action(ACT_RETX, win_base + i[SEQ_FIELD_W-1:0],
                                        (i + 1 == int'(outs)));
                        end
                        if (int'(outs) > longest_burst) longest_burst = int'(outs);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [ACK_W-1:0] ack);
        in_word_t w;
        w.kind       = kind;
        w.ack_number = ack;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        advance_window(w);
        words_in++;
    endtask

    task automatic idle_gap(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sender_actions_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx == CFG_WINDOW_SIZE) begin
            win_size_reg = data[WS_W-1:0];
        end else begin
            timeout_reg = data[TO_W-1:0];
        end
        reg_writes++;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic ack_all();
        logic [SEQ_FIELD_W-1:0] last_seq;
        if (next_seq != win_base) begin
            last_seq = next_seq - 1'b1;
            send_word(KIND_ACK, last_seq);
        end
    endtask

    task automatic test_default_window();
        int i;
        for (i = 0; i < 5; i++) send_word(KIND_NEW, 8'h00);
        send_word(KIND_TICK, 8'hA5);
        send_word(KIND_UNUSED, 8'hFF);
        send_word(KIND_ACK, 8'd200);
        send_word(KIND_ACK, 8'd1);
        send_word(KIND_NEW, 8'h5A);
        send_word(KIND_ACK, 8'hFF);
        send_word(KIND_ACK, 8'd4);
        send_word(KIND_TICK, 8'h00);
    endtask

    task automatic test_zero_settings();
        set_reg(CFG_WINDOW_SIZE, 16'd0);
        set_reg(CFG_TIMEOUT_TICKS, 16'd0);
        send_word(KIND_NEW, 8'h00);
        send_word(KIND_NEW, 8'h00);
        send_word(KIND_TICK, 8'h00);
        send_word(KIND_TICK, 8'h00);
        ack_all();
    endtask

    task automatic test_full_window_resend();
        int i;
        set_reg(CFG_WINDOW_SIZE, 16'd63);
        set_reg(CFG_TIMEOUT_TICKS, 16'd65535);
        for (i = 0; i < 33; i++) send_word(KIND_NEW, 8'h00);
        send_word(KIND_TICK, 8'h00);
        set_reg(CFG_TIMEOUT_TICKS, 16'd1);
        send_word(KIND_TICK, 8'h00);
    endtask

    task automatic test_shrunk_window();
        logic [SEQ_FIELD_W-1:0] ack;
        set_reg(CFG_WINDOW_SIZE, 16'd2);
        send_word(KIND_NEW, 8'h00);
        ack = win_base + 8'd29;
        send_word(KIND_ACK, ack);
        send_word(KIND_NEW, 8'h00);
        send_word(KIND_ACK, win_base);
        send_word(KIND_NEW, 8'h00);
        ack_all();
    endtask

    task automatic test_output_stall();
        int i;
        set_reg(CFG_WINDOW_SIZE, 16'd32);
        set_reg(CFG_TIMEOUT_TICKS, 16'd65535);
        hold_request = 200;
        for (i = 0; i < 30; i++) send_word(KIND_NEW, 8'h00);
        ack_all();
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] ws, input logic [CFG_DATA_W-1:0] to,
                             input int count, input bit gaps, input int mode);
        int i;
        int roll;
        int burst_left;
        logic [SEQ_FIELD_W-1:0] outs;
        logic [ACK_W-1:0] ack;
        set_reg(CFG_WINDOW_SIZE, ws);
        set_reg(CFG_TIMEOUT_TICKS, to);
        ready_mode = mode;
        burst_left = $urandom_range(1, 12);
        for (i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            outs = next_seq - win_base;
            ack  = ACK_W'($urandom_range(0, 255));
            if (roll < 58) begin
                send_word(KIND_NEW, ack);
            end else if (roll < 83) begin
                if (outs != 0) begin
                    ack = win_base + ACK_W'($urandom_range(0, int'(outs) - 1));
                end
                send_word(KIND_ACK, ack);
            end else if (roll < 95) begin
                send_word(KIND_TICK, ack);
            end else if (roll < 98) begin
                send_word(KIND_ACK, ack);
            end else begin
                send_word(KIND_UNUSED, ack);
            end
            if (gaps) begin
                burst_left--;
                if (burst_left == 0) begin
                    idle_gap($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 12);
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        run_phase(16'd63, 16'd3, 57, 1'b1, READY_RANDOM);
        run_phase(16'd1, 16'd1, 57, 1'b0, READY_ALWAYS);
        run_phase(16'd17, 16'd65535, 57, 1'b1, READY_PATTERN);
        run_phase(16'd0, 16'd0, 57, 1'b1, READY_RANDOM);
        run_phase(16'd32, 16'd2, 57, 1'b0, READY_PATTERN);
        run_phase(CFG_DATA_W'($urandom_range(1, 32)), CFG_DATA_W'($urandom_range(1, 6)),
                  57, 1'b1, READY_RANDOM);
    endtask

    // Receiver: a long hold-off when asked, otherwise the current stall pattern.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    READY_RANDOM:  m_ready <= ($urandom_range(0, 99) < 70);
                    READY_PATTERN: m_ready <= ready_pattern[0];
                    default:       m_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_words
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            case (m_data.action)
                ACT_SEND: sends_seen++;
                ACT_RETX: retx_seen++;
                default:  refused_seen++;
            endcase
            if (sender_actions_q.size() == 0) begin
                report_mismatch("unexpected word, action", int'(m_data.action), -1);
            end else begin
                want = sender_actions_q.pop_front();
                if (m_data.action != want.action)
                    report_mismatch("action", int'(m_data.action), int'(want.action));
                if (m_data.sequence_res != want.sequence_res)
                    report_mismatch("sequence_res", int'(m_data.sequence_res),
                                    int'(want.sequence_res));
                if (m_data.last != want.last)
                    report_mismatch("last", int'(m_data.last), int'(want.last));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > WATCHDOG_CYCLES) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, sender_actions_q.size());
            $display("[go_back_n_sender_window] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_window();
        test_zero_settings();
        test_full_window_resend();
        test_shrunk_window();
        test_output_stall();
        test_random_traffic();
        wait_idle();
        $display("covered %0d input words and %0d register writes over %0d cycles",
                 words_in, reg_writes, cycle_count);
        $display("saw %0d sends, %0d resends (longest burst %0d), %0d refusals, %0d errors",
                 sends_seen, retx_seen, longest_burst, refused_seen, err_count);
        if (err_count == 0) begin
            $display("[go_back_n_sender_window] OK");
        end else begin
            $display("[go_back_n_sender_window] ERROR");
        end
        $finish;
    end

endmodule
